>>> rtl/core/robi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package robi_pkg;

    // Field formats
    localparam int COORD_BITS = 21;
    localparam int FRAC_BITS  = 12;
    localparam int NUM_AX     = 3;
    localparam int FIELD_W    = 63;
    localparam int OUT_W      = 29;
    localparam int LIMIT_W    = 20;

    // Datapath widths
    localparam int PROD_W  = 2 * COORD_BITS;              // coord * coord
    localparam int ACC_W   = PROD_W + 2;                  // world center at 2F
    localparam int D_W     = ACC_W - FRAC_BITS + 1;       // center - origin
    localparam int F_W     = PROD_W + 2;                  // dir . axis
    localparam int EP_W    = COORD_BITS + D_W;            // axis * d
    localparam int E_W     = EP_W + 2;                    // axis . d
    localparam int EXT_W   = COORD_BITS + FRAC_BITS;      // extent at 2F
    localparam int NUM_W   = E_W + 1;                     // e -/+ extent
    localparam int DEN_W   = F_W;                         // |f|
    localparam int QBIG_SH = 36;                          // integer part limit
    localparam int Q_W     = QBIG_SH + FRAC_BITS;         // quotient bits
    localparam int QSAT_SH = 52;
    localparam int T_W     = QSAT_SH + 2;                 // signed t values

    localparam int DIV_LANES = 2 * NUM_AX;
    localparam int DIV_STEPS = Q_W;

    localparam logic [T_W-1:0] T_SAT      = T_W'(1) << QSAT_SH;
    localparam logic [T_W-1:0] T_FAR_INIT = T_W'(100000) << FRAC_BITS;

    // Register file
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam logic [COORD_BITS-1:0] DIR_Z_RESET = COORD_BITS'(1) << FRAC_BITS;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET = LIMIT_W'(16777);

    typedef enum logic [2:0] {
        REG_ORG_X = 3'd0,
        REG_ORG_Y = 3'd1,
        REG_ORG_Z = 3'd2,
        REG_DIR_X = 3'd3,
        REG_DIR_Y = 3'd4,
        REG_DIR_Z = 3'd5,
        REG_LIMIT = 3'd6
    } reg_idx_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t [NUM_AX-1:0]  org;
        coord_t [NUM_AX-1:0]  dir;
        logic [LIMIT_W-1:0]   limit;
    } cfg_t;

    // Per-axis flags that ride along with the divider
    typedef struct packed {
        logic par;      // near-parallel axis, containment test only
        logic fail;     // containment test fails
        logic neg_lo;
        logic neg_hi;
        logic sat_lo;
        logic sat_hi;
    } axis_side_t;

    typedef axis_side_t [NUM_AX-1:0]                side_vec_t;
    typedef logic [DIV_LANES-1:0][NUM_W-1:0]        num_vec_t;
    typedef logic [NUM_AX-1:0][DEN_W-1:0]           den_vec_t;
    typedef logic [DIV_LANES-1:0][Q_W-1:0]          q_vec_t;

    // Component k of a packed triple
    function automatic coord_t comp(input logic [FIELD_W-1:0] p, input int k);
        return p[k*COORD_BITS +: COORD_BITS];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/robi_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Box word channel
interface robi_box_if;
    logic                          valid;
    logic                          ready;
    logic [robi_pkg::FIELD_W-1:0]  axis_x_col;
    logic [robi_pkg::FIELD_W-1:0]  axis_y_col;
    logic [robi_pkg::FIELD_W-1:0]  axis_z_col;
    logic [robi_pkg::FIELD_W-1:0]  translation_col;
    logic [robi_pkg::FIELD_W-1:0]  box_center;
    logic [robi_pkg::FIELD_W-1:0]  box_extents;

    modport source (
        output valid, axis_x_col, axis_y_col, axis_z_col,
        output translation_col, box_center, box_extents,
        input  ready
    );
    modport sink (
        input  valid, axis_x_col, axis_y_col, axis_z_col,
        input  translation_col, box_center, box_extents,
        output ready
    );
endinterface

// Hit word channel
interface robi_hit_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [robi_pkg::OUT_W-1:0]  entry_distance;

    modport source (output valid, hit, entry_distance, input ready);
    modport sink   (input valid, hit, entry_distance, output ready);
endinterface

`default_nettype wire

>>> rtl/core/robi_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module robi_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [robi_pkg::APB_AW-1:0]   paddr,
    input  logic [robi_pkg::APB_DW-1:0]   pwdata,
    output logic [robi_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output robi_pkg::cfg_t                cfg
);
    import robi_pkg::*;

    logic [COORD_BITS-1:0] org_reg [NUM_AX];
    logic [COORD_BITS-1:0] dir_reg [NUM_AX];
    logic [LIMIT_W-1:0]    limit_reg;
    logic                  wr_en;
    reg_idx_t              idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AX; i++)
            begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
            dir_reg[2] <= DIR_Z_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ORG_X: org_reg[0] <= pwdata[COORD_BITS-1:0];
                REG_ORG_Y: org_reg[1] <= pwdata[COORD_BITS-1:0];
                REG_ORG_Z: org_reg[2] <= pwdata[COORD_BITS-1:0];
                REG_DIR_X: dir_reg[0] <= pwdata[COORD_BITS-1:0];
                REG_DIR_Y: dir_reg[1] <= pwdata[COORD_BITS-1:0];
                REG_DIR_Z: dir_reg[2] <= pwdata[COORD_BITS-1:0];
                REG_LIMIT: limit_reg  <= pwdata[LIMIT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_ORG_X: prdata = APB_DW'(org_reg[0]);
            REG_ORG_Y: prdata = APB_DW'(org_reg[1]);
            REG_ORG_Z: prdata = APB_DW'(org_reg[2]);
            REG_DIR_X: prdata = APB_DW'(dir_reg[0]);
            REG_DIR_Y: prdata = APB_DW'(dir_reg[1]);
            REG_DIR_Z: prdata = APB_DW'(dir_reg[2]);
            REG_LIMIT: prdata = APB_DW'(limit_reg);
            default:   prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AX; i++)
        begin
            cfg.org[i] = org_reg[i];
            cfg.dir[i] = dir_reg[i];
        end
        cfg.limit = limit_reg;
    end

endmodule

`default_nettype wire

>>> rtl/core/robi_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Five stages: products, world center and f, e products, e sums, magnitudes.
module robi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [robi_pkg::FIELD_W-1:0]  axis_x_col,
    input  logic [robi_pkg::FIELD_W-1:0]  axis_y_col,
    input  logic [robi_pkg::FIELD_W-1:0]  axis_z_col,
    input  logic [robi_pkg::FIELD_W-1:0]  translation_col,
    input  logic [robi_pkg::FIELD_W-1:0]  box_center,
    input  logic [robi_pkg::FIELD_W-1:0]  box_extents,
    input  robi_pkg::cfg_t                cfg,
    output logic                          out_valid,
    output robi_pkg::num_vec_t            nums,
    output robi_pkg::den_vec_t            dens,
    output robi_pkg::side_vec_t           side
);
    import robi_pkg::*;

    // Unpacked input fields
    coord_t a_in   [NUM_AX][NUM_AX];
    coord_t ctr_in [NUM_AX];
    coord_t tr_in  [NUM_AX];
    coord_t ext_in [NUM_AX];

    logic [4:0] valid_reg;

    // Stage 1
    logic signed [PROD_W-1:0] s1_cprod_reg [NUM_AX][NUM_AX];
    logic signed [PROD_W-1:0] s1_fprod_reg [NUM_AX][NUM_AX];
    coord_t                   s1_a_reg     [NUM_AX][NUM_AX];
    coord_t                   s1_tr_reg    [NUM_AX];
    coord_t                   s1_ext_reg   [NUM_AX];
    // Stage 2
    logic signed [ACC_W-1:0]  acc          [NUM_AX];
    logic signed [D_W-1:0]    s2_d_next    [NUM_AX];
    logic signed [F_W-1:0]    s2_f_next    [NUM_AX];
    logic signed [D_W-1:0]    s2_d_reg     [NUM_AX];
    logic signed [F_W-1:0]    s2_f_reg     [NUM_AX];
    coord_t                   s2_a_reg     [NUM_AX][NUM_AX];
    coord_t                   s2_ext_reg   [NUM_AX];
    // Stage 3
    logic signed [F_W-1:0]    lim_s;
    logic signed [EP_W-1:0]   s3_eprod_reg [NUM_AX][NUM_AX];
    logic signed [EXT_W-1:0]  s3_ext_reg   [NUM_AX];
    logic signed [F_W-1:0]    s3_f_reg     [NUM_AX];
    logic                     s3_par_reg   [NUM_AX];
    // Stage 4
    logic signed [E_W-1:0]    e_sum        [NUM_AX];
    logic signed [NUM_W-1:0]  s4_lo_reg    [NUM_AX];
    logic signed [NUM_W-1:0]  s4_hi_reg    [NUM_AX];
    logic signed [F_W-1:0]    s4_f_reg     [NUM_AX];
    logic                     s4_par_reg   [NUM_AX];
    // Stage 5
    num_vec_t                 s5_num_next;
    den_vec_t                 s5_den_next;
    side_vec_t                s5_side_next;
    num_vec_t                 s5_num_reg;
    den_vec_t                 s5_den_reg;
    side_vec_t                s5_side_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AX; i++)
        begin
            a_in[0][i] = comp(axis_x_col, i);
            a_in[1][i] = comp(axis_y_col, i);
            a_in[2][i] = comp(axis_z_col, i);
            ctr_in[i]  = comp(box_center, i);
            tr_in[i]   = comp(translation_col, i);
            ext_in[i]  = comp(box_extents, i);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    // Stage 1: center and direction products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NUM_AX; k++)
            begin
                for (int i = 0; i < NUM_AX; i++)
                begin
                    s1_cprod_reg[k][i] <= PROD_W'(a_in[k][i]) * PROD_W'(ctr_in[k]);
                    s1_fprod_reg[k][i] <= PROD_W'($signed(cfg.dir[i])) * PROD_W'(a_in[k][i]);
                    s1_a_reg[k][i]     <= a_in[k][i];
                end
                s1_tr_reg[k]  <= tr_in[k];
                s1_ext_reg[k] <= ext_in[k];
            end
        end
    end

    // Stage 2: world center, d = center - origin, f = dir . axis
    always_comb
    begin
        for (int i = 0; i < NUM_AX; i++)
        begin
            acc[i] = (ACC_W'(s1_tr_reg[i]) <<< FRAC_BITS) + ACC_W'(s1_cprod_reg[0][i])
                   + ACC_W'(s1_cprod_reg[1][i]) + ACC_W'(s1_cprod_reg[2][i]);
            s2_d_next[i] = D_W'(acc[i] >>> FRAC_BITS) - D_W'($signed(cfg.org[i]));
            s2_f_next[i] = F_W'(s1_fprod_reg[i][0]) + F_W'(s1_fprod_reg[i][1])
                         + F_W'(s1_fprod_reg[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_d_reg   <= s2_d_next;
            s2_f_reg   <= s2_f_next;
            s2_a_reg   <= s1_a_reg;
            s2_ext_reg <= s1_ext_reg;
        end
    end

    // Stage 3: axis . d products, parallel check
    assign lim_s = F_W'(cfg.limit);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NUM_AX; k++)
            begin
                for (int i = 0; i < NUM_AX; i++)
                    s3_eprod_reg[k][i] <= EP_W'(s2_a_reg[k][i]) * EP_W'(s2_d_reg[i]);
                s3_ext_reg[k] <= EXT_W'(s2_ext_reg[k]) <<< FRAC_BITS;
                s3_f_reg[k]   <= s2_f_reg[k];
                s3_par_reg[k] <= (s2_f_reg[k] <= lim_s) && (s2_f_reg[k] >= -lim_s);
            end
        end
    end

    // Stage 4: slab numerators
    always_comb
    begin
        for (int k = 0; k < NUM_AX; k++)
            e_sum[k] = E_W'(s3_eprod_reg[k][0]) + E_W'(s3_eprod_reg[k][1])
                     + E_W'(s3_eprod_reg[k][2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NUM_AX; k++)
            begin
                s4_lo_reg[k]  <= NUM_W'(e_sum[k]) - NUM_W'(s3_ext_reg[k]);
                s4_hi_reg[k]  <= NUM_W'(e_sum[k]) + NUM_W'(s3_ext_reg[k]);
                s4_f_reg[k]   <= s3_f_reg[k];
                s4_par_reg[k] <= s3_par_reg[k];
            end
        end
    end

    // Stage 5: magnitudes, signs, saturation and containment flags
    always_comb
    begin
        for (int k = 0; k < NUM_AX; k++)
        begin
            s5_num_next[2*k]   = s4_lo_reg[k][NUM_W-1] ? NUM_W'(-s4_lo_reg[k])
                                                       : NUM_W'(s4_lo_reg[k]);
            s5_num_next[2*k+1] = s4_hi_reg[k][NUM_W-1] ? NUM_W'(-s4_hi_reg[k])
                                                       : NUM_W'(s4_hi_reg[k]);
            s5_den_next[k]     = s4_f_reg[k][F_W-1] ? DEN_W'(-s4_f_reg[k])
                                                    : DEN_W'(s4_f_reg[k]);
            s5_side_next[k].par    = s4_par_reg[k];
            s5_side_next[k].fail   = s4_hi_reg[k][NUM_W-1]
                                   || (!s4_lo_reg[k][NUM_W-1] && (s4_lo_reg[k] != '0));
            s5_side_next[k].neg_lo = s4_lo_reg[k][NUM_W-1] ^ s4_f_reg[k][F_W-1];
            s5_side_next[k].neg_hi = s4_hi_reg[k][NUM_W-1] ^ s4_f_reg[k][F_W-1];
            // integer part of the quotient reaches 2^36
            s5_side_next[k].sat_lo = DEN_W'(s5_num_next[2*k][NUM_W-1:QBIG_SH])
                                   >= s5_den_next[k];
            s5_side_next[k].sat_hi = DEN_W'(s5_num_next[2*k+1][NUM_W-1:QBIG_SH])
                                   >= s5_den_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_num_reg  <= s5_num_next;
            s5_den_reg  <= s5_den_next;
            s5_side_reg <= s5_side_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign nums      = s5_num_reg;
    assign dens      = s5_den_reg;
    assign side      = s5_side_reg;

endmodule

`default_nettype wire

>>> rtl/core/robi_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, six lanes.
// Lane 2k uses den k for the near slab, lane 2k+1 for the far slab.
module robi_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  robi_pkg::num_vec_t   nums,
    input  robi_pkg::den_vec_t   dens,
    input  robi_pkg::side_vec_t  side_in,
    output logic                 out_valid,
    output robi_pkg::q_vec_t     quots,
    output robi_pkg::side_vec_t  side_out
);
    import robi_pkg::*;

    logic [DEN_W-1:0] rem_src  [DIV_STEPS][DIV_LANES];
    logic [Q_W-1:0]   qn_src   [DIV_STEPS][DIV_LANES];
    den_vec_t         den_src  [DIV_STEPS];
    side_vec_t        side_src [DIV_STEPS];

    logic [DEN_W:0]   trial    [DIV_STEPS][DIV_LANES];
    logic             ge       [DIV_STEPS][DIV_LANES];
    logic [DEN_W-1:0] rem_next [DIV_STEPS][DIV_LANES];
    logic [Q_W-1:0]   qn_next  [DIV_STEPS][DIV_LANES];

    logic [DEN_W-1:0] rem_reg  [DIV_STEPS][DIV_LANES];
    logic [Q_W-1:0]   qn_reg   [DIV_STEPS][DIV_LANES];
    den_vec_t         den_reg  [DIV_STEPS];
    side_vec_t        side_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] valid_reg;

    // Stage inputs: the front end or the previous stage
    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            rem_src[0][l] = DEN_W'(nums[l][NUM_W-1:QBIG_SH]);
            qn_src[0][l]  = {nums[l][QBIG_SH-1:0], FRAC_BITS'(0)};
        end
        den_src[0]  = dens;
        side_src[0] = side_in;
        for (int j = 1; j < DIV_STEPS; j++)
        begin
            for (int l = 0; l < DIV_LANES; l++)
            begin
                rem_src[j][l] = rem_reg[j-1][l];
                qn_src[j][l]  = qn_reg[j-1][l];
            end
            den_src[j]  = den_reg[j-1];
            side_src[j] = side_reg[j-1];
        end
    end

    // One compare-subtract per lane and stage; quotient bits shift in at the bottom
    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            for (int l = 0; l < DIV_LANES; l++)
            begin
                trial[j][l]    = {rem_src[j][l], qn_src[j][l][Q_W-1]};
                ge[j][l]       = trial[j][l] >= {1'b0, den_src[j][l >> 1]};
                rem_next[j][l] = ge[j][l] ? DEN_W'(trial[j][l] - {1'b0, den_src[j][l >> 1]})
                                          : DEN_W'(trial[j][l]);
                qn_next[j][l]  = {qn_src[j][l][Q_W-2:0], ge[j][l]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[DIV_STEPS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            qn_reg   <= qn_next;
            den_reg  <= den_src;
            side_reg <= side_src;
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign side_out  = side_reg[DIV_STEPS-1];

    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
            quots[l] = qn_reg[DIV_STEPS-1][l];
    end

endmodule

`default_nettype wire

>>> rtl/core/robi_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Three stages: signed slab pair sort, interval narrowing, hit word register.
module robi_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  robi_pkg::q_vec_t            quots,
    input  robi_pkg::side_vec_t         side,
    output logic                        out_valid,
    output logic                        hit,
    output logic [robi_pkg::OUT_W-1:0]  entry_distance
);
    import robi_pkg::*;

    logic [2:0]              valid_reg;

    logic [T_W-1:0]          mag_lo  [NUM_AX];
    logic [T_W-1:0]          mag_hi  [NUM_AX];
    logic signed [T_W-1:0]   t_lo    [NUM_AX];
    logic signed [T_W-1:0]   t_hi    [NUM_AX];
    logic signed [T_W-1:0]   b1_t1_reg   [NUM_AX];
    logic signed [T_W-1:0]   b1_t2_reg   [NUM_AX];
    logic                    b1_par_reg  [NUM_AX];
    logic                    b1_fail_reg [NUM_AX];

    logic signed [T_W-1:0]   tnear_next;
    logic signed [T_W-1:0]   tfar_next;
    logic                    ok_next;
    logic signed [T_W-1:0]   b2_tnear_reg;
    logic signed [T_W-1:0]   b2_tfar_reg;
    logic                    b2_ok_reg;

    logic                    hit_next;
    logic                    hit_reg;
    logic [OUT_W-1:0]        entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    // Stage 1: apply saturation and sign, order the slab pair
    always_comb
    begin
        for (int k = 0; k < NUM_AX; k++)
        begin
            mag_lo[k] = side[k].sat_lo ? T_SAT : T_W'(quots[2*k]);
            mag_hi[k] = side[k].sat_hi ? T_SAT : T_W'(quots[2*k+1]);
            t_lo[k]   = side[k].neg_lo ? -$signed(mag_lo[k]) : $signed(mag_lo[k]);
            t_hi[k]   = side[k].neg_hi ? -$signed(mag_hi[k]) : $signed(mag_hi[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NUM_AX; k++)
            begin
                b1_t1_reg[k]   <= (t_lo[k] > t_hi[k]) ? t_hi[k] : t_lo[k];
                b1_t2_reg[k]   <= (t_lo[k] > t_hi[k]) ? t_lo[k] : t_hi[k];
                b1_par_reg[k]  <= side[k].par;
                b1_fail_reg[k] <= side[k].fail;
            end
        end
    end

    // Stage 2: narrow [t_near, t_far]; parallel axes only test containment
    always_comb
    begin
        tnear_next = '0;
        tfar_next  = $signed(T_FAR_INIT);
        ok_next    = 1'b1;
        for (int k = 0; k < NUM_AX; k++)
        begin
            if (b1_par_reg[k])
            begin
                if (b1_fail_reg[k])
                    ok_next = 1'b0;
            end
            else
            begin
                if (b1_t1_reg[k] > tnear_next)
                    tnear_next = b1_t1_reg[k];
                if (b1_t2_reg[k] < tfar_next)
                    tfar_next = b1_t2_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_tnear_reg <= tnear_next;
            b2_tfar_reg  <= tfar_next;
            b2_ok_reg    <= ok_next;
        end
    end

    // Stage 3: hit word
    assign hit_next = b2_ok_reg && (b2_tfar_reg >= b2_tnear_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg   <= hit_next;
            entry_reg <= hit_next ? b2_tnear_reg[OUT_W-1:0] : '0;
        end
    end

    assign out_valid      = valid_reg[2];
    assign hit            = hit_reg;
    assign entry_distance = entry_reg;

endmodule

`default_nettype wire

>>> rtl/core/ray_oriented_box_intersect_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width             Contents
// box       in   6 x 63 + hs       axis columns, translation, center, extents
// result    out  1 + 29 + hs       hit, entry distance (Q17.12)
// apb       in   5 addr, 32 data   ray origin, direction, parallel limit
//
// One box word per cycle unless the output stalls; stages: 5 front, 48 divider, 3 back.
// The divider retires one quotient bit per stage for the near and far bounds of three slabs, six lanes in parallel.
// rst_n clears all valid bits and loads the register reset values.
// The whole pipeline holds while the output word waits; nothing is dropped.
module ray_oriented_box_intersect_core (
    input  logic                          clk,
    input  logic                          rst_n,
    robi_box_if.sink                      box,
    robi_hit_if.source                    result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [robi_pkg::APB_AW-1:0]   paddr,
    input  logic [robi_pkg::APB_DW-1:0]   pwdata,
    output logic [robi_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import robi_pkg::*;

    cfg_t       cfg;
    logic       adv;
    logic       front_valid;
    num_vec_t   nums;
    den_vec_t   dens;
    side_vec_t  front_side;
    logic       div_valid;
    q_vec_t     quots;
    side_vec_t  div_side;
    logic       back_valid;

    // Global advance: move when the output register is free or being taken
    assign adv       = !back_valid || result.ready;
    assign box.ready = adv;

    robi_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    robi_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (box.valid),
        .axis_x_col      (box.axis_x_col),
        .axis_y_col      (box.axis_y_col),
        .axis_z_col      (box.axis_z_col),
        .translation_col (box.translation_col),
        .box_center      (box.box_center),
        .box_extents     (box.box_extents),
        .cfg             (cfg),
        .out_valid       (front_valid),
        .nums            (nums),
        .dens            (dens),
        .side            (front_side)
    );

    robi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .nums      (nums),
        .dens      (dens),
        .side_in   (front_side),
        .out_valid (div_valid),
        .quots     (quots),
        .side_out  (div_side)
    );

    robi_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (div_valid),
        .quots          (quots),
        .side           (div_side),
        .out_valid      (back_valid),
        .hit            (result.hit),
        .entry_distance (result.entry_distance)
    );

    assign result.valid = back_valid;

endmodule

`default_nettype wire

>>> rtl/core/robi_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module robi_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        hit,
    input logic [robi_pkg::OUT_W-1:0]  entry_distance
);
    import robi_pkg::*;

    // A waiting hit word stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("hit word dropped while stalled");

    // Input is open whenever the output register is empty
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("box channel blocked with empty output");

    // Miss carries zero distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> entry_distance == '0)
        else $error("miss with nonzero entry distance");

    // Entry never beyond the far limit
    a_entry_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_distance <= OUT_W'(T_FAR_INIT))
        else $error("entry distance beyond far limit");

endmodule

bind ray_oriented_box_intersect_core robi_chk u_robi_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (box.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .hit            (result.hit),
    .entry_distance (result.entry_distance)
);

`default_nettype wire

>>> verif/robi_slab_checker.sv
`timescale 1ns / 1ps

// Watches the box and hit channels and the register port, predicts each
// hit word from the box word and the current ray, and compares in order.
module robi_slab_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    robi_box_if                           box,
    robi_hit_if                           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [robi_pkg::APB_AW-1:0]   paddr,
    input  logic [robi_pkg::APB_DW-1:0]   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending,
    output int                            boxes_seen,
    output int                            hits_seen
);
    import robi_pkg::*;

    typedef struct {
        logic                hit;
        logic [OUT_W-1:0]    distance;
    } hit_word_t;

    hit_word_t expected_hits[$];

    coord_t             ray_org[NUM_AX];
    coord_t             ray_dir[NUM_AX];
    logic [LIMIT_W-1:0] par_limit;

    assign pending = expected_hits.size();

    function automatic longint part(input logic [FIELD_W-1:0] p, input int k);
        coord_t c;
        c = p[k*COORD_BITS +: COORD_BITS];
        return longint'(c);
    endfunction

    // Exact quotient at F fraction bits, truncated toward zero, saturated
    function automatic longint slab_div(input longint num, input longint den);
        logic [63:0] n, dv, q0, r, mag;
        if (den == 0)
            return 0;
        n   = (num < 0) ? -num : num;
        dv  = (den < 0) ? -den : den;
        q0  = n / dv;
        r   = n % dv;
        if (q0 >= (64'd1 << QBIG_SH))
            mag = 64'd1 << QSAT_SH;
        else
            mag = (q0 << FRAC_BITS) + ((r << FRAC_BITS) / dv);
        return ((num < 0) != (den < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic hit_word_t slab_test(input logic [FIELD_W-1:0] cols[6]);
        hit_word_t w;
        longint one, tnear, tfar, lim, acc, e, f, ext, t1, t2, sw;
        longint dvec[NUM_AX];
        logic hit;
        one   = longint'(1) << FRAC_BITS;
        tnear = 0;
        tfar  = longint'(100000) * one;
        lim   = longint'(par_limit);
        hit   = 1'b1;
        // world center relative to origin
        for (int i = 0; i < NUM_AX; i++)
        begin
            acc = part(cols[3], i) * one;
            for (int k = 0; k < NUM_AX; k++)
                acc += part(cols[k], i) * part(cols[4], k);
            dvec[i] = (acc >>> FRAC_BITS) - longint'(ray_org[i]);
        end
        // one slab per box axis
        for (int k = 0; k < NUM_AX; k++)
        begin
            if (hit)
            begin
                e = 0;
                f = 0;
                for (int i = 0; i < NUM_AX; i++)
                begin
                    e += part(cols[k], i) * dvec[i];
                    f += longint'(ray_dir[i]) * part(cols[k], i);
                end
                ext = part(cols[5], k) * one;
                if (f > lim || f < -lim)
                begin
                    t1 = slab_div(e - ext, f);
                    t2 = slab_div(e + ext, f);
                    if (t1 > t2)
                    begin
                        sw = t1;
                        t1 = t2;
                        t2 = sw;
                    end
                    if (t2 < tfar)
                        tfar = t2;
                    if (t1 > tnear)
                        tnear = t1;
                    if (tfar < tnear)
                        hit = 1'b0;
                end
                else if (-e - ext > 0 || -e + ext < 0)
                begin
                    hit = 1'b0;
                end
            end
        end
        w.hit      = hit;
        w.distance = hit ? tnear[OUT_W-1:0] : '0;
        return w;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Register snoop
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_org   <= '{default: '0};
            ray_dir   <= '{'0, '0, DIR_Z_RESET};
            par_limit <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx_t'(paddr[APB_AW-1:2]))
                REG_ORG_X: ray_org[0] <= pwdata[COORD_BITS-1:0];
                REG_ORG_Y: ray_org[1] <= pwdata[COORD_BITS-1:0];
                REG_ORG_Z: ray_org[2] <= pwdata[COORD_BITS-1:0];
                REG_DIR_X: ray_dir[0] <= pwdata[COORD_BITS-1:0];
                REG_DIR_Y: ray_dir[1] <= pwdata[COORD_BITS-1:0];
                REG_DIR_Z: ray_dir[2] <= pwdata[COORD_BITS-1:0];
                REG_LIMIT: par_limit  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    initial
    begin
        fail_count = 0;
        boxes_seen = 0;
        hits_seen  = 0;
    end

    // Box words: predict
    always @(posedge clk)
    begin
        logic [FIELD_W-1:0] cols[6];
        if (rst_n && box.valid && box.ready)
        begin
            cols[0] = box.axis_x_col;
            cols[1] = box.axis_y_col;
            cols[2] = box.axis_z_col;
            cols[3] = box.translation_col;
            cols[4] = box.box_center;
            cols[5] = box.box_extents;
            expected_hits.insert(expected_hits.size(), slab_test(cols));
            boxes_seen++;
        end
    end

    // Hit words: compare with the oldest prediction
    always @(posedge clk)
    begin
        hit_word_t w;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_hits.size() == 0)
            begin
                report("unexpected hit word", result.hit, 0);
            end
            else
            begin
                w = expected_hits.pop_front();
                if (result.hit !== w.hit)
                    report("hit", result.hit, w.hit);
                if (result.entry_distance !== w.distance)
                    report("entry_distance", result.entry_distance, w.distance);
                if (w.hit)
                    hits_seen++;
            end
        end
    end

endmodule

>>> verif/tb_ray_oriented_box_intersect_core.sv
`timescale 1ns / 1ps

module tb_ray_oriented_box_intersect_core;
    import robi_pkg::*;

    localparam int LATENCY    = 56;
    localparam int STALL_LEN  = 300;
    localparam int IDLE_LIMIT = 3000;
    localparam int PHASE_LEN  = 155;
    localparam int ONE        = 4096;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int  fail_count;
    int  pending;
    int  boxes_seen;
    int  hits_seen;
    int  settings_run;
    bit  long_hold;
    bit  no_idle;

    robi_box_if box ();
    robi_hit_if result ();

    ray_oriented_box_intersect_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .box     (box.sink),
        .result  (result.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    robi_slab_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .box        (box),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .boxes_seen (boxes_seen),
        .hits_seen  (hits_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [FIELD_W-1:0] triple(input int x, input int y, input int z);
        logic [COORD_BITS-1:0] a, b, c;
        a = x[COORD_BITS-1:0];
        b = y[COORD_BITS-1:0];
        c = z[COORD_BITS-1:0];
        return {c, b, a};
    endfunction

    function automatic int srand(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [FIELD_W-1:0] raw_field();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[FIELD_W-1:0];
    endfunction

    task automatic reg_write(input reg_idx_t idx, input int value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_AW'(idx) << 2;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_ray(input int ox, input int oy, input int oz,
                           input int dx, input int dy, input int dz, input int lim);
        reg_write(REG_ORG_X, ox);
        reg_write(REG_ORG_Y, oy);
        reg_write(REG_ORG_Z, oz);
        reg_write(REG_DIR_X, dx);
        reg_write(REG_DIR_Y, dy);
        reg_write(REG_DIR_Z, dz);
        reg_write(REG_LIMIT, lim);
        settings_run++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_box(input logic [FIELD_W-1:0] ax, input logic [FIELD_W-1:0] ay,
                            input logic [FIELD_W-1:0] az, input logic [FIELD_W-1:0] tr,
                            input logic [FIELD_W-1:0] ct, input logic [FIELD_W-1:0] ex);
        int gap;
        gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            box.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        box.axis_x_col      = ax;
        box.axis_y_col      = ay;
        box.axis_z_col      = az;
        box.translation_col = tr;
        box.box_center      = ct;
        box.box_extents     = ex;
        box.valid           = 1'b1;
        do
            @(posedge clk);
        while (!box.ready);
        @(negedge clk);
    endtask

    // Mostly plausible boxes near the ray, some raw noise and degenerate axes
    task automatic send_random_box();
        int kind;
        logic [FIELD_W-1:0] ax, ay, az;
        kind = $urandom_range(0, 19);
        if (kind < 4)
        begin
            send_box(raw_field(), raw_field(), raw_field(), raw_field(),
                     raw_field(), raw_field());
        end
        else
        begin
            ax = triple(srand(-ONE, ONE), srand(-ONE, ONE), srand(-ONE, ONE));
            ay = triple(srand(-ONE, ONE), srand(-ONE, ONE), srand(-ONE, ONE));
            az = triple(srand(-ONE, ONE), srand(-ONE, ONE), srand(-ONE, ONE));
            if (kind == 4)
                ay = triple(srand(-2, 2), srand(-2, 2), srand(-2, 2));
            send_box(ax, ay, az,
                     triple(srand(-20*ONE, 20*ONE), srand(-20*ONE, 20*ONE),
                            srand(-20*ONE, 20*ONE)),
                     triple(srand(-4*ONE, 4*ONE), srand(-4*ONE, 4*ONE),
                            srand(-4*ONE, 4*ONE)),
                     triple(srand(kind == 5 ? -8*ONE : 0, 8*ONE), srand(0, 8*ONE),
                            srand(kind == 6 ? -8*ONE : 0, 8*ONE)));
        end
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // Result side: random back-pressure plus one long stall on request
    initial
    begin
        int gap;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                result.ready = 1'b0;
                repeat (STALL_LEN) @(negedge clk);
                long_hold = 1'b0;
            end
            gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                result.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            result.ready = 1'b1;
            do
                @(posedge clk);
            while (!result.valid);
        end
    end

    // Watchdog: cycles without any word moving
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((box.valid && box.ready) || (result.valid && result.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [FIELD_W-1:0] id_x, id_y, id_z, zero3;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        long_hold = 1'b0;
        no_idle   = 1'b0;
        settings_run = 1;
        box.valid = 1'b0;
        box.axis_x_col = '0;
        box.axis_y_col = '0;
        box.axis_z_col = '0;
        box.translation_col = '0;
        box.box_center = '0;
        box.box_extents = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        id_x  = triple(ONE, 0, 0);
        id_y  = triple(0, ONE, 0);
        id_z  = triple(0, 0, ONE);
        zero3 = '0;

        // Directed, reset ray along +z
        send_box(id_x, id_y, id_z, zero3, triple(0, 0, 5*ONE), triple(ONE, ONE, ONE));
        send_box(id_x, id_y, id_z, zero3, triple(0, 0, -5*ONE), triple(ONE, ONE, ONE));
        send_box(id_x, id_y, id_z, zero3, zero3, triple(ONE, ONE, ONE));
        send_box(id_x, id_y, id_z, zero3, triple(0, 0, 5*ONE), triple(-ONE, -ONE, -ONE));
        send_box(id_x, id_y, id_z, triple(3*ONE, 0, 8*ONE), zero3, triple(ONE, ONE, ONE));
        send_box(id_x, id_y, zero3, zero3, triple(0, 0, 5*ONE), triple(ONE, ONE, ONE));
        send_box(id_x, id_y, id_z, triple(0, 0, 2*ONE), zero3, triple(ONE, ONE, 0));
        send_box(zero3, zero3, zero3, zero3, zero3, zero3);
        send_box('1, '1, '1, '1, '1, '1);
        send_box(triple(1048575, 1048575, 1048575), triple(1048575, 1048575, 1048575),
                 triple(1048575, 1048575, 1048575), triple(1048575, 1048575, 1048575),
                 triple(1048575, 1048575, 1048575), triple(1048575, 1048575, 1048575));
        send_box(triple(-1048576, -1048576, -1048576), triple(-1048576, -1048576, -1048576),
                 triple(-1048576, -1048576, -1048576), triple(-1048576, -1048576, -1048576),
                 triple(-1048576, -1048576, -1048576), triple(-1048576, -1048576, -1048576));
        send_box(id_x, id_y, triple(0, 0, 1), zero3, triple(0, 0, 1048575),
                 triple(1048575, 1048575, 1048575));
        send_box(id_x, id_y, id_z, zero3, triple(0, 0, 1048575), triple(ONE, ONE, 1));
        repeat (8)
            send_box(raw_field(), raw_field(), raw_field(), raw_field(),
                     raw_field(), raw_field());
        repeat (PHASE_LEN) send_random_box();

        // Several ray settings; the second one runs with a long output stall
        for (int phase = 0; phase < 8; phase++)
        begin
            box.valid = 1'b0;
            drain();
            case (phase)
                0: set_ray(0, 0, -20*ONE, 0, 0, ONE, 16777);
                1: set_ray(srand(-10*ONE, 10*ONE), srand(-10*ONE, 10*ONE),
                           srand(-10*ONE, 10*ONE), srand(-2*ONE, 2*ONE),
                           srand(-2*ONE, 2*ONE), srand(-2*ONE, 2*ONE),
                           $urandom_range(0, 100000));
                2: set_ray(1048575, -1048576, 0, -1048576, 1048575, 0, 1048575);
                3: set_ray(0, 0, 0, 0, 0, 0, 0);
                4: set_ray(-1048576, 1048575, -1048576, 1, 0, -1048576, 0);
                5: set_ray(ONE, -ONE, 0, ONE, ONE, 0, 1);
                default: set_ray(srand(-10*ONE, 10*ONE), srand(-10*ONE, 10*ONE),
                                 srand(-10*ONE, 10*ONE), srand(-2*ONE, 2*ONE),
                                 srand(-2*ONE, 2*ONE), srand(-2*ONE, 2*ONE),
                                 $urandom_range(0, 1048575));
            endcase
            no_idle   = (phase == 5);
            long_hold = (phase == 1);
            repeat (PHASE_LEN) send_random_box();
        end
        box.valid = 1'b0;
        no_idle   = 1'b0;
        drain();

        $display("Ran %0d boxes under %0d ray settings; %0d hits, one long output stall.",
                 boxes_seen, settings_run, hits_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/robi_pkg.sv
rtl/core/robi_if.sv
rtl/core/robi_cfg.sv
rtl/core/robi_front.sv
rtl/core/robi_div.sv
rtl/core/robi_back.sv
rtl/core/ray_oriented_box_intersect_core.sv
rtl/core/robi_chk.sv
verif/robi_slab_checker.sv
verif/tb_ray_oriented_box_intersect_core.sv
